@@ hw/rtl/dotq_pkg.sv @@
package dotq_pkg;

    localparam int DEPTH      = 16;
    localparam int TIME_BITS  = 32;
    localparam int ID_BITS    = 8;
    localparam int MODE_BITS  = 2;
    localparam int DELAY_BITS = 16;
    localparam int OUT_ID_BITS = 8;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    localparam logic [MODE_BITS-1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_TICK     = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_UPDATE   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_NONE     = 2'd3;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   task_id;
    } entry_t;

    typedef struct packed {
        logic                 insert;
        logic                 pop;
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   task_id;
        logic [TIME_BITS-1:0] time_now;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/dotq_in_if.sv @@
interface dotq_in_if import dotq_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [MODE_BITS-1:0]  mode;
    logic [7:0]            task_id;
    logic [DELAY_BITS-1:0] delay;

    modport source (output valid, output mode, output task_id, output delay, input ready);
    modport sink   (input valid, input mode, input task_id, input delay, output ready);
endinterface

@@ hw/rtl/dotq_out_if.sv @@
interface dotq_out_if import dotq_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   fired;
    logic [OUT_ID_BITS-1:0] fired_id;
    logic                   last;
    logic                   status;
    logic                   queue_empty;
    logic [COUNT_BITS-1:0]  queue_count;

    modport source (output valid, output fired, output fired_id, output last, output status,
                    output queue_empty, output queue_count, input ready);
    modport sink   (input valid, input fired, input fired_id, input last, input status,
                    input queue_empty, input queue_count, output ready);
endinterface

@@ hw/rtl/dotq_cell.sv @@
module dotq_cell import dotq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     prev_entry,
    input  logic       prev_ge,
    input  entry_t     next_entry,
    output entry_t     entry,
    output logic       ge,
    output logic       due
);

    logic                 valid_reg;
    logic [TIME_BITS-1:0] deadline_reg;
    logic [ID_BITS-1:0]   task_reg;
    entry_t               entry_next;
    logic                 load;

    assign entry = {valid_reg, deadline_reg, task_reg};
    assign ge    = !valid_reg || (deadline_reg >= ctrl.deadline);
    assign due   = valid_reg && (deadline_reg <= ctrl.time_now);

    // On a pop every cell takes its successor's entry. Otherwise a new item goes in at the first
    // cell whose deadline is equal or later; every cell behind it takes its predecessor's entry.
    always_comb
    begin
        entry_next = entry;
        load       = 1'b0;
        if (ctrl.pop)
        begin
            entry_next = next_entry;
            load       = 1'b1;
        end
        else if (ctrl.insert && ge)
        begin
            load = 1'b1;
            if (prev_ge)
            begin
                entry_next = prev_entry;
            end
            else
            begin
                entry_next.valid    = 1'b1;
                entry_next.deadline = ctrl.deadline;
                entry_next.task_id  = ctrl.task_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            deadline_reg <= entry_next.deadline;
            task_reg     <= entry_next.task_id;
        end
    end

endmodule

@@ hw/rtl/deadline_ordered_timer_queue.sv @@
// Every result is registered; an item's first result appears in the cycle after it is accepted.
// Schedule, tick and idle items leave the queue idle and may follow back to back while the output is not stalled.
// An update gives one result per released task (a single result if none is due), as the
// chain of cells shifts one entry toward the head per result; no new item is taken meanwhile.
// Asynchronous active-low reset clears the cell valid bits, count, time and
// output valid; stored deadlines and task ids are not cleared.
module deadline_ordered_timer_queue import dotq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    dotq_in_if.sink    cmd,
    dotq_out_if.source rsp
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                  state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [TIME_BITS-1:0]  time_reg, time_next;

    logic                   rsp_valid_reg;
    logic                   rsp_fired_reg, rsp_fired_next;
    logic [OUT_ID_BITS-1:0] rsp_id_reg, rsp_id_next;
    logic                   rsp_last_reg, rsp_last_next;
    logic                   rsp_status_reg, rsp_status_next;
    logic [COUNT_BITS-1:0]  rsp_count_reg;

    cell_ctrl_t ctrl;
    entry_t     cell_q    [DEPTH];
    entry_t     cell_prev [DEPTH];
    entry_t     cell_nxt  [DEPTH];
    logic       cell_ge   [DEPTH];
    logic       cell_pge  [DEPTH];
    logic       cell_due  [DEPTH];
    logic [DEPTH-1:0] valid_vec;

    logic                 out_free;
    logic                 accept;
    logic                 load_rsp;
    logic                 full;
    logic [TIME_BITS:0]   deadline_sum;
    logic [TIME_BITS-1:0] deadline;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign cell_prev[gi] = '0;
                assign cell_pge[gi]  = 1'b0;
            end
            else
            begin : g_body
                assign cell_prev[gi] = cell_q[gi-1];
                assign cell_pge[gi]  = cell_ge[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_tail
                assign cell_nxt[gi] = '0;
            end
            else
            begin : g_mid
                assign cell_nxt[gi] = cell_q[gi+1];
            end
            assign valid_vec[gi] = cell_q[gi].valid;

            dotq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_entry (cell_prev[gi]),
                .prev_ge    (cell_pge[gi]),
                .next_entry (cell_nxt[gi]),
                .entry      (cell_q[gi]),
                .ge         (cell_ge[gi]),
                .due        (cell_due[gi])
            );
        end
    endgenerate

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = out_free && (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == COUNT_BITS'(DEPTH));

    assign deadline_sum = {1'b0, time_reg} + (TIME_BITS + 1)'(cmd.delay);
    assign deadline     = deadline_sum[TIME_BITS] ? TIME_MAX : deadline_sum[TIME_BITS-1:0];

    always_comb
    begin
        ctrl.insert     = 1'b0;
        ctrl.pop        = 1'b0;
        ctrl.deadline   = deadline;
        ctrl.task_id    = cmd.task_id[ID_BITS-1:0];
        ctrl.time_now   = time_reg;
        state_next      = state_reg;
        count_next      = count_reg;
        time_next       = time_reg;
        load_rsp        = 1'b0;
        rsp_fired_next  = 1'b0;
        rsp_id_next     = '0;
        rsp_last_next   = 1'b1;
        rsp_status_next = 1'b0;

        if (accept)
        begin
            load_rsp = 1'b1;
            unique case (cmd.mode)
                MODE_SCHEDULE:
                begin
                    if (full)
                    begin
                        rsp_status_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    if (time_reg != TIME_MAX)
                    begin
                        time_next = time_reg + 1'b1;
                    end
                end
                MODE_UPDATE:
                begin
                    if (cell_due[0])
                    begin
                        ctrl.pop = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if ((state_reg == ST_DRAIN) && out_free)
        begin
            load_rsp = 1'b1;
            ctrl.pop = 1'b1;
        end

        if (ctrl.pop)
        begin
            count_next     = count_reg - 1'b1;
            rsp_fired_next = 1'b1;
            rsp_id_next    = OUT_ID_BITS'(cell_q[0].task_id);
            rsp_last_next  = !cell_due[1];
            state_next     = cell_due[1] ? ST_DRAIN : ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            time_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            time_reg  <= time_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_fired_reg  <= rsp_fired_next;
            rsp_id_reg     <= rsp_id_next;
            rsp_last_reg   <= rsp_last_next;
            rsp_status_reg <= rsp_status_next;
            rsp_count_reg  <= count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.fired       = rsp_fired_reg;
    assign rsp.fired_id    = rsp_id_reg;
    assign rsp.last        = rsp_last_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.queue_count = rsp_count_reg;
    assign rsp.queue_empty = (rsp_count_reg == '0);

`ifndef SYNTHESIS
    // The count must match the number of occupied cells.
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(valid_vec))
        else $error("count does not match occupied cells");

    // While draining, the head cell always holds a due task.
    a_drain_head_due: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_due[0])
        else $error("drain without a due head task");

    // A result without a released task always closes its item.
    a_idle_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_fired_reg) |-> rsp_last_reg)
        else $error("non-fired result without last");

    // A dropped schedule leaves the queue full.
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg) |-> (rsp_count_reg == COUNT_BITS'(DEPTH)))
        else $error("drop reported with room in the queue");
`endif

endmodule
